### hw/rtl/teals_pkg.sv
// Shared constants, codes and control types of the timed event scheduler.
package teals_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int ACTIVE_DEPTH = 64;
    localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
    localparam int ACTIVE_AW    = $clog2(ACTIVE_DEPTH);
    localparam int ACNT_W       = ACTIVE_AW + 1;
    localparam int NEXT_W       = TABLE_AW + 1;
    localparam int TIME_W       = 31;

    localparam int IN_FIELDS_W  = TABLE_AW + 3 * TIME_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = TABLE_AW + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_ID,
        ST_WALK_CMP,
        ST_WALK_MOVE,
        ST_APP_RD,
        ST_APP_CMP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic tick;
        logic act_rd;
        logic act_rd_last;
        logic stop_rd;
        logic move;
        logic app_rd;
        logic append;
        logic drop;
        logic emit;
        logic emit_app;
        logic ne_inc;
        logic i_inc;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic i_lt_cnt;
        logic stop_due;
        logic ev_avail;
        logic start_due;
        logic list_full;
        logic can_emit;
        logic out_free;
    } dp_status_t;

endpackage

### hw/rtl/teals_ctrl.sv
// Controller state machine that sequences table loads and tick processing.
module teals_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_op,
    output logic                in_ready,
    input  teals_pkg::dp_status_t sts,
    output teals_pkg::ctl_cmd_t   cmd
);
    import teals_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_op == OP_TICK)
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD:
            begin
                state_next = sts.i_lt_cnt ? ST_WALK_ID : ST_APP_RD;
            end
            ST_WALK_ID:
            begin
                state_next = ST_WALK_CMP;
            end
            ST_WALK_CMP:
            begin
                if (sts.stop_due)
                begin
                    state_next = ST_WALK_MOVE;
                end
                else if (sts.can_emit)
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_MOVE:
            begin
                state_next = ST_WALK_RD;
            end
            ST_APP_RD:
            begin
                state_next = sts.ev_avail ? ST_APP_CMP : ST_FINISH;
            end
            ST_APP_CMP:
            begin
                if (!sts.start_due)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.list_full || sts.can_emit)
                begin
                    state_next = ST_APP_RD;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.tick = (in_op == OP_TICK);
                    cmd.load = (in_op == OP_LOAD);
                end
            end
            ST_WALK_RD:
            begin
                cmd.act_rd = sts.i_lt_cnt;
            end
            ST_WALK_ID:
            begin
                cmd.stop_rd = 1'b1;
            end
            ST_WALK_CMP:
            begin
                if (sts.stop_due)
                begin
                    cmd.act_rd_last = 1'b1;
                end
                else if (sts.can_emit)
                begin
                    cmd.emit  = 1'b1;
                    cmd.i_inc = 1'b1;
                end
            end
            ST_WALK_MOVE:
            begin
                cmd.move = 1'b1;
            end
            ST_APP_RD:
            begin
                cmd.app_rd = sts.ev_avail;
            end
            ST_APP_CMP:
            begin
                if (sts.start_due)
                begin
                    if (sts.list_full)
                    begin
                        cmd.drop   = 1'b1;
                        cmd.ne_inc = 1'b1;
                    end
                    else if (sts.can_emit)
                    begin
                        cmd.append   = 1'b1;
                        cmd.emit     = 1'b1;
                        cmd.emit_app = 1'b1;
                        cmd.ne_inc   = 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### hw/rtl/teals_dp.sv
// Datapath with event tables, active list memory, counters and the result registers.
module teals_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  teals_pkg::ctl_cmd_t               cmd,
    output teals_pkg::dp_status_t             sts,
    input  logic [teals_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [teals_pkg::NEXT_W-1:0]      cfg_data,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [teals_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);
    import teals_pkg::*;

    logic [TIME_W-1:0]   start_mem [TABLE_DEPTH];
    logic [TIME_W-1:0]   stop_mem  [TABLE_DEPTH];
    logic [TABLE_AW-1:0] act_mem   [ACTIVE_DEPTH];

    logic [TABLE_AW-1:0] in_index;
    logic [TIME_W-1:0]   in_start;
    logic [TIME_W-1:0]   in_stop;
    logic [TIME_W-1:0]   in_now;

    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   start_rd_reg;
    logic [TIME_W-1:0]   stop_rd_reg;
    logic [TABLE_AW-1:0] act_id_reg;
    logic [NEXT_W-1:0]   event_count_reg;
    logic [NEXT_W-1:0]   next_event_reg;
    logic [NEXT_W-1:0]   limit;
    logic [ACNT_W-1:0]   act_cnt_reg;
    logic [ACNT_W-1:0]   walk_idx_reg;
    logic [ACNT_W-1:0]   cnt_minus_one;
    logic                dropped_reg;

    logic                act_we;
    logic                act_re;
    logic [ACTIVE_AW-1:0] act_waddr;
    logic [ACTIVE_AW-1:0] act_raddr;
    logic [TABLE_AW-1:0] act_wdata;

    logic                pend_valid_reg;
    logic [TABLE_AW-1:0] pend_id_reg;
    logic [TABLE_AW-1:0] emit_id;
    logic                out_valid_reg;
    logic [TABLE_AW-1:0] out_id_reg;
    logic                out_fired_reg;
    logic                out_ovf_reg;
    logic                out_last_reg;
    logic                out_free;

    assign in_index = s_axis_tdata[TABLE_AW-1:0];
    assign in_start = s_axis_tdata[TABLE_AW +: TIME_W];
    assign in_stop  = s_axis_tdata[TABLE_AW + TIME_W +: TIME_W];
    assign in_now   = s_axis_tdata[TABLE_AW + 2 * TIME_W +: TIME_W];

    assign cfg_ready = 1'b1;

    assign limit = (event_count_reg > NEXT_W'(TABLE_DEPTH)) ? NEXT_W'(TABLE_DEPTH)
                                                             : event_count_reg;
    assign cnt_minus_one = act_cnt_reg - ACNT_W'(1);
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign sts.i_lt_cnt  = walk_idx_reg < act_cnt_reg;
    assign sts.stop_due  = stop_rd_reg <= now_reg;
    assign sts.ev_avail  = next_event_reg < limit;
    assign sts.start_due = start_rd_reg <= now_reg;
    assign sts.list_full = act_cnt_reg >= ACNT_W'(ACTIVE_DEPTH);
    assign sts.can_emit  = !pend_valid_reg || out_free;
    assign sts.out_free  = out_free;

    assign act_we    = cmd.move || cmd.append;
    assign act_waddr = cmd.move ? walk_idx_reg[ACTIVE_AW-1:0] : act_cnt_reg[ACTIVE_AW-1:0];
    assign act_wdata = cmd.move ? act_id_reg : next_event_reg[TABLE_AW-1:0];
    assign act_re    = cmd.act_rd || cmd.act_rd_last;
    assign act_raddr = cmd.act_rd_last ? cnt_minus_one[ACTIVE_AW-1:0]
                                       : walk_idx_reg[ACTIVE_AW-1:0];
    assign emit_id   = cmd.emit_app ? next_event_reg[TABLE_AW-1:0] : act_id_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_mem[in_index] <= in_start;
        end
        if (cmd.app_rd)
        begin
            start_rd_reg <= start_mem[next_event_reg[TABLE_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            stop_mem[in_index] <= in_stop;
        end
        if (cmd.stop_rd)
        begin
            stop_rd_reg <= stop_mem[act_id_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (act_we)
        begin
            act_mem[act_waddr] <= act_wdata;
        end
        if (act_re)
        begin
            act_id_reg <= act_mem[act_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick)
        begin
            now_reg <= in_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_count_reg <= '0;
            next_event_reg  <= '0;
            act_cnt_reg     <= '0;
            walk_idx_reg    <= '0;
            dropped_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                event_count_reg <= cfg_data;
            end
            if (cmd.ne_inc)
            begin
                next_event_reg <= next_event_reg + NEXT_W'(1);
            end
            if (cmd.move)
            begin
                act_cnt_reg <= cnt_minus_one;
            end
            else if (cmd.append)
            begin
                act_cnt_reg <= act_cnt_reg + ACNT_W'(1);
            end
            if (cmd.tick)
            begin
                walk_idx_reg <= '0;
            end
            else if (cmd.i_inc)
            begin
                walk_idx_reg <= walk_idx_reg + ACNT_W'(1);
            end
            if (cmd.tick || cmd.finish)
            begin
                dropped_reg <= 1'b0;
            end
            else if (cmd.drop)
            begin
                dropped_reg <= 1'b1;
            end
        end
    end

    // The newest emission waits in a pending slot until the next one or the
    // end of the tick shows whether it is the tick's final result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.finish || (cmd.emit && pend_valid_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pend_id_reg <= emit_id;
        end
        if (cmd.emit && pend_valid_reg)
        begin
            out_id_reg    <= pend_id_reg;
            out_fired_reg <= 1'b1;
            out_ovf_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_id_reg    <= pend_valid_reg ? pend_id_reg : '0;
            out_fired_reg <= pend_valid_reg;
            out_ovf_reg   <= dropped_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_ovf_reg, out_id_reg};
    assign m_axis_tuser  = out_fired_reg;
    assign m_axis_tlast  = out_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        act_cnt_reg <= ACNT_W'(ACTIVE_DEPTH))
        else $error("active list count exceeds its depth");

    a_next_grows: assert property (@(posedge clk) disable iff (!rst_n)
        next_event_reg >= $past(next_event_reg))
        else $error("next event pointer moved backwards");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && pend_valid_reg) |-> out_free)
        else $error("emission would overwrite an untaken result");

    a_finish_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (out_valid_reg && out_last_reg && !pend_valid_reg))
        else $error("final result of a tick was not presented");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.act_rd |-> (walk_idx_reg < act_cnt_reg))
        else $error("active list read beyond its fill");

endmodule

### hw/rtl/timed_event_active_list_scheduler.sv
// Top level of the timed event scheduler with an active list.
// A load transaction writes one table entry. After a tick transaction no input is taken
// until the tick has walked the active list, keeping or retiring each entry, has appended
// or dropped due events, has stopped at a table event not yet due, and output stalls end.
// Reset clears the counters, event_count, the output and the state machine.
module timed_event_active_list_scheduler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // entry_index[7:0], start_time[38:8], stop_time[69:39], now[100:70], zero padding
    input  logic [teals_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                              s_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [teals_pkg::NEXT_W-1:0]      cfg_data,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // event_id[7:0], overflow[8], zero padding
    output logic [teals_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // fired
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);
    import teals_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t sts;

    teals_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    teals_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
